### rtl/oct_pkg.sv
package oct_pkg;

    localparam logic [0:0] CFG_MODE = 1'd0;
    localparam logic [0:0] CFG_DIR  = 1'd1;

    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_RGB   = 2'd1;
    localparam logic [1:0] MODE_BAYER = 2'd2;

    localparam logic DIR_INV = 1'b0;
    localparam logic DIR_FWD = 1'b1;

    localparam logic [1:0] MODE_RESET = MODE_RGB;
    localparam logic       DIR_RESET  = DIR_FWD;

    // Coefficients as fractions of 2^32.
    localparam logic [63:0] Q32_INV_SQRT3 = 64'd2479700524;
    localparam logic [63:0] Q32_INV_SQRT2 = 64'd3037000500;
    localparam logic [63:0] Q32_HALF      = 64'd2147483648;
    localparam logic [63:0] Q32_SQRT2_3   = 64'd3506826112;

    // Rounds a 32-bit fraction to coef_bits-1 fraction bits.
    function automatic logic [63:0] coef_of(input logic [63:0] q32, input int coef_bits);
        int drop;
        drop = 33 - coef_bits;
        return (q32 + (64'd1 << (drop - 1))) >> drop;
    endfunction

endpackage

### rtl/orthonormal_color_transform_core.sv
// Orthonormal opponent color transform, one pixel per request.
//
// The slave stream carries one pixel of four signed Q12.6 samples in tdata
// and the master stream returns the transformed pixel in the same layout.
// A separate write channel sets the mode register (index 0) and the
// direction register (index 1); it is always ready and must only be used
// while no pixel is in flight.
//
// The datapath has four register stages: operand pre-sums at the input,
// the four products, the combined sums with the rounding term, and the
// saturated result. An accepted request passes through them in that order,
// and one request is taken every cycle while a stage is free or the receiver takes a result.
//
// When the receiver stalls, the result register holds and the stages
// behind it keep filling; the slave side deasserts tready only once all
// four stages are occupied. Reset empties the pipeline and sets the
// block to the three-channel forward transform.
module orthonormal_color_transform_core #(
    parameter int SAMPLE_BITS = 18,
    parameter int COEF_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // Fields from bit 0 up: chan_a, chan_b, chan_c, chan_d, zero pad.
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // Fields from bit 0 up: res_a, res_b, res_c, res_d, zero pad.
    output logic [((4*SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [1:0]             i_cfg_data
);

    localparam int SB      = SAMPLE_BITS;
    localparam int CB      = COEF_BITS;
    localparam int TDATA_W = ((4*SB+7)/8)*8;
    localparam int OPW     = SB + 2;
    localparam int PW      = OPW + CB;
    localparam int AW      = PW + 3;

    localparam logic signed [CB-1:0] C_A =
        CB'(oct_pkg::coef_of(oct_pkg::Q32_INV_SQRT3, CB));
    localparam logic signed [CB-1:0] C_B =
        CB'(oct_pkg::coef_of(oct_pkg::Q32_INV_SQRT2, CB));
    localparam logic signed [CB-1:0] C_H =
        CB'(oct_pkg::coef_of(oct_pkg::Q32_HALF, CB));
    localparam logic signed [CB-1:0] C_C =
        CB'(oct_pkg::coef_of(oct_pkg::Q32_SQRT2_3, CB));

    localparam logic signed [AW-1:0] ROUND_ADD = AW'(1) <<< (CB - 1);
    localparam logic signed [AW-1:0] SAT_MAX = {{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_MIN = {{(AW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    logic [1:0] r_mode;
    logic       r_dir;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic signed [SB-1:0]  w_x   [4];
    logic signed [OPW-1:0] n_op  [4];
    logic signed [OPW-1:0] r_op  [4];
    logic signed [CB-1:0]  w_coef[4];
    logic signed [PW-1:0]  r_prod[4];
    logic signed [AW-1:0]  w_m   [4];
    logic signed [AW-1:0]  n_acc [4];
    logic signed [AW-1:0]  r_acc [4];
    logic signed [AW-1:0]  w_shr [4];
    logic [4*SB-1:0]       n_res;
    logic [4*SB-1:0]       r_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= oct_pkg::MODE_RESET;
            r_dir  <= oct_pkg::DIR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == oct_pkg::CFG_MODE) begin
                r_mode <= i_cfg_data;
            end else begin
                r_dir <= i_cfg_data[0];
            end
        end
    end

    assign w_rdy4 = !r_v4 || i_m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_s_axis_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_x[k] = i_s_axis_tdata[k*SB +: SB];
        end
    end

    always_comb begin
        logic signed [OPW-1:0] e0, e1, e2, e3;
        e0 = OPW'(w_x[0]);
        e1 = OPW'(w_x[1]);
        e2 = OPW'(w_x[2]);
        e3 = OPW'(w_x[3]);
        n_op[0] = '0;
        n_op[1] = '0;
        n_op[2] = '0;
        n_op[3] = '0;
        unique case (r_mode)
            oct_pkg::MODE_PASS: begin
                n_op[0] = e0 + e0;
            end
            oct_pkg::MODE_RGB: begin
                if (r_dir == oct_pkg::DIR_FWD) begin
                    n_op[0] = e0 + e1 + e2;
                    n_op[1] = e0 - e2;
                    n_op[2] = e0 - e1 - e1 + e2;
                end else begin
                    n_op[0] = e0;
                    n_op[1] = e1;
                    n_op[2] = e2;
                end
            end
            default: begin
                if (r_dir == oct_pkg::DIR_FWD) begin
                    n_op[0] = e0 + e1 + e2 + e3;
                    n_op[1] = e1 - e2;
                    n_op[2] = e1 + e2 - e0 - e3;
                    n_op[3] = e3 - e0;
                end else begin
                    n_op[0] = e0 - e2;
                    n_op[1] = e0 + e2;
                    n_op[2] = e1;
                    n_op[3] = e3;
                end
            end
        endcase
    end

    always_comb begin
        w_coef[0] = C_H;
        w_coef[1] = C_B;
        w_coef[2] = C_H;
        w_coef[3] = C_B;
        unique case (r_mode)
            oct_pkg::MODE_PASS: begin
                w_coef[0] = C_H;
            end
            oct_pkg::MODE_RGB: begin
                w_coef[0] = C_A;
                w_coef[1] = C_B;
                w_coef[2] = C_C;
            end
            default: begin
                if (r_dir == oct_pkg::DIR_INV) begin
                    w_coef[1] = C_H;
                    w_coef[2] = C_B;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_op <= n_op;
        if (w_rdy2) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= PW'(r_op[k]) * PW'(w_coef[k]);
            end
        end
        if (w_rdy3) r_acc <= n_acc;
        if (w_rdy4) r_res <= n_res;
    end

    always_comb begin
        logic signed [AW-1:0] s0, s1, s2, s3;
        for (int k = 0; k < 4; k++) begin
            w_m[k] = AW'(r_prod[k]);
        end
        s0 = w_m[0] + w_m[0];
        s1 = w_m[1] + w_m[1];
        s2 = w_m[2] + w_m[2];
        s3 = w_m[3] + w_m[3];
        n_acc[0] = ROUND_ADD;
        n_acc[1] = ROUND_ADD;
        n_acc[2] = ROUND_ADD;
        n_acc[3] = ROUND_ADD;
        unique case (r_mode)
            oct_pkg::MODE_PASS: begin
                n_acc[0] = s0 + ROUND_ADD;
            end
            oct_pkg::MODE_RGB: begin
                if (r_dir == oct_pkg::DIR_FWD) begin
                    n_acc[0] = s0 + ROUND_ADD;
                    n_acc[1] = s1 + ROUND_ADD;
                    n_acc[2] = w_m[2] + ROUND_ADD;
                end else begin
                    n_acc[0] = s0 + s1 + w_m[2] + ROUND_ADD;
                    n_acc[1] = s0 - s2 + ROUND_ADD;
                    n_acc[2] = s0 - s1 + w_m[2] + ROUND_ADD;
                end
            end
            default: begin
                if (r_dir == oct_pkg::DIR_FWD) begin
                    n_acc[0] = s0 + ROUND_ADD;
                    n_acc[1] = s1 + ROUND_ADD;
                    n_acc[2] = s2 + ROUND_ADD;
                    n_acc[3] = s3 + ROUND_ADD;
                end else begin
                    n_acc[0] = s0 - s3 + ROUND_ADD;
                    n_acc[1] = s1 + s2 + ROUND_ADD;
                    n_acc[2] = s1 - s2 + ROUND_ADD;
                    n_acc[3] = s0 + s3 + ROUND_ADD;
                end
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_shr[k] = r_acc[k] >>> CB;
            if (w_shr[k] > SAT_MAX) begin
                n_res[k*SB +: SB] = SAT_MAX[SB-1:0];
            end else if (w_shr[k] < SAT_MIN) begin
                n_res[k*SB +: SB] = SAT_MIN[SB-1:0];
            end else begin
                n_res[k*SB +: SB] = w_shr[k][SB-1:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = TDATA_W'(r_res);

`ifndef ASSERT_OFF
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input blocked while the pipeline has a free stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_v1)
        else $error("accepted request did not enter the first stage");

    a_pass_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_mode == oct_pkg::MODE_PASS
        |-> r_res[4*SB-1:SB] == '0)
        else $error("pass-through result has nonzero upper channels");

    a_rgb_zero_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_mode == oct_pkg::MODE_RGB
        |-> r_res[4*SB-1:3*SB] == '0)
        else $error("three-channel result has nonzero fourth channel");
`endif

endmodule

### verif/orthonormal_color_transform_core_tb.sv
module orthonormal_color_transform_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = 18;
    localparam int COEF_BITS   = 16;
    localparam int TDATA_W     = ((4 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAC        = COEF_BITS - 1;
    localparam int COEF_DROP   = 33 - COEF_BITS;
    localparam int PIPE_DEPTH  = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Matrix coefficients in Q1.15.
    localparam longint K_SQRT3 =
        (oct_pkg::Q32_INV_SQRT3 + (64'd1 << (COEF_DROP - 1))) >> COEF_DROP;
    localparam longint K_SQRT2 =
        (oct_pkg::Q32_INV_SQRT2 + (64'd1 << (COEF_DROP - 1))) >> COEF_DROP;
    localparam longint K_HALF =
        (oct_pkg::Q32_HALF + (64'd1 << (COEF_DROP - 1))) >> COEF_DROP;
    localparam longint K_S23 =
        (oct_pkg::Q32_SQRT2_3 + (64'd1 << (COEF_DROP - 1))) >> COEF_DROP;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] d;
        logic signed [SAMPLE_BITS-1:0] c;
        logic signed [SAMPLE_BITS-1:0] b;
        logic signed [SAMPLE_BITS-1:0] a;
    } t_pixel;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [1:0]         cfg_data = 2'd0;

    logic [1:0] cur_mode = oct_pkg::MODE_RESET;
    logic       cur_dir = oct_pkg::DIR_RESET;

    t_pixel expected_pixels[$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     burst_left = 0;
    bit     tx_gapless = 1'b0;
    int     hold_req = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     rx_pattern = 0;
    int     rx_tick = 0;

    orthonormal_color_transform_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEF_BITS  (COEF_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input longint acc,
                                                                input int s);
        longint r;
        longint hi;
        longint lo;
        hi = longint'(S_MAX);
        lo = longint'(S_MIN);
        r = (acc + (64'sd1 <<< (s - 1))) >>> s;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_pixel transform_pixel(input t_pixel px);
        t_pixel o;
        longint x0;
        longint x1;
        longint x2;
        longint x3;
        x0 = px.a;
        x1 = px.b;
        x2 = px.c;
        x3 = px.d;
        o = '0;
        if (cur_mode == oct_pkg::MODE_PASS) begin
            o.a = round_sat(x0 <<< FRAC, FRAC);
        end else if (cur_mode == oct_pkg::MODE_RGB) begin
            if (cur_dir == oct_pkg::DIR_FWD) begin
                o.a = round_sat(K_SQRT3 * (x0 + x1 + x2), FRAC);
                o.b = round_sat(K_SQRT2 * (x0 - x2), FRAC);
                o.c = round_sat(K_S23 * (x0 - 2 * x1 + x2), FRAC + 1);
            end else begin
                o.a = round_sat(2 * K_SQRT3 * x0 + 2 * K_SQRT2 * x1 + K_S23 * x2, FRAC + 1);
                o.b = round_sat(K_SQRT3 * x0 - K_S23 * x2, FRAC);
                o.c = round_sat(2 * K_SQRT3 * x0 - 2 * K_SQRT2 * x1 + K_S23 * x2, FRAC + 1);
            end
        end else begin
            if (cur_dir == oct_pkg::DIR_FWD) begin
                o.a = round_sat(K_HALF * (x0 + x1 + x2 + x3), FRAC);
                o.b = round_sat(K_SQRT2 * (x1 - x2), FRAC);
                o.c = round_sat(K_HALF * (-x0 + x1 + x2 - x3), FRAC);
                o.d = round_sat(K_SQRT2 * (x3 - x0), FRAC);
            end else begin
                o.a = round_sat(K_HALF * x0 - K_HALF * x2 - K_SQRT2 * x3, FRAC);
                o.b = round_sat(K_HALF * x0 + K_SQRT2 * x1 + K_HALF * x2, FRAC);
                o.c = round_sat(K_HALF * x0 - K_SQRT2 * x1 + K_HALF * x2, FRAC);
                o.d = round_sat(K_HALF * x0 - K_HALF * x2 + K_SQRT2 * x3, FRAC);
            end
        end
        return o;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 4) return SAMPLE_BITS'($urandom());
        if (kind <= 7) return SAMPLE_BITS'($signed($urandom_range(0, 600)) - 300);
        if (kind == 8) return S_MAX;
        return S_MIN;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        px.a = rand_sample();
        px.b = rand_sample();
        px.c = rand_sample();
        px.d = rand_sample();
        return px;
    endfunction

    // Receiver: checks every accepted result and stalls on a changing pattern.
    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (m_tvalid && m_tready) begin
            got = m_tdata[4*SAMPLE_BITS-1:0];
            if (expected_pixels.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected pixel: %0d %0d %0d %0d",
                             got.a, got.b, got.c, got.d);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    if (error_count < 10)
                        $display("pixel mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.a, want.b, want.c, want.d,
                                 got.a, got.b, got.c, got.d);
                    error_count++;
                end
            end
        end
        rx_tick++;
        if (rx_tick % 50 == 0)
            rx_pattern = $urandom_range(0, 3);
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_pattern)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (rx_tick % 5 != 0);
            endcase
        end
    end

    task automatic send_pixel(input t_pixel px);
        int gap;
        if (!tx_gapless) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata <= TDATA_W'(px);
        do @(posedge i_clk); while (!s_tready);
        expected_pixels.push_back(transform_pixel(px));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == oct_pkg::CFG_MODE) cur_mode = value;
        else cur_dir = value[0];
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_transform(input logic [1:0] mode, input logic dir);
        wait_all_results();
        write_reg(oct_pkg::CFG_MODE, mode);
        write_reg(oct_pkg::CFG_DIR, {1'b0, dir});
    endtask

    task automatic test_reset_defaults();
        send_pixel('{d: S_MIN, c: S_MAX, b: S_MIN, a: S_MAX});
        send_pixel('{d: S_MAX, c: S_MAX, b: S_MAX, a: S_MAX});
        send_pixel('{d: S_MIN, c: S_MIN, b: S_MIN, a: S_MIN});
        send_pixel('{d: SAMPLE_BITS'(1), c: SAMPLE_BITS'(-1),
                     b: SAMPLE_BITS'(1), a: SAMPLE_BITS'(-1)});
    endtask

    task automatic test_all_settings();
        logic [1:0] modes[4];
        modes = '{oct_pkg::MODE_PASS, oct_pkg::MODE_RGB, oct_pkg::MODE_BAYER, MODE_SPARE};
        for (int m = 0; m < 4; m++) begin
            for (int k = 0; k < 2; k++) begin
                set_transform(modes[m], k[0]);
                send_pixel('{d: S_MIN, c: S_MAX, b: S_MIN, a: S_MAX});
                send_pixel('{d: S_MAX, c: SAMPLE_BITS'(-1), b: S_MAX, a: S_MIN});
            end
        end
    endtask

    task automatic test_random_pixels();
        logic [1:0] modes[4];
        logic [1:0] mode;
        modes = '{oct_pkg::MODE_PASS, oct_pkg::MODE_RGB, oct_pkg::MODE_BAYER, MODE_SPARE};
        for (int p = 0; p < 10; p++) begin
            mode = (p < 4) ? modes[p] : modes[$urandom_range(0, 3)];
            set_transform(mode, (p < 4) ? p[0] : 1'($urandom_range(0, 1)));
            tx_gapless = (p % 3 == 0);
            repeat (40) send_pixel(rand_pixel());
        end
        tx_gapless = 1'b0;
    endtask

    task automatic test_output_stall();
        set_transform(oct_pkg::MODE_BAYER, oct_pkg::DIR_FWD);
        tx_gapless = 1'b1;
        hold_req++;
        repeat (40) send_pixel(rand_pixel());
        tx_gapless = 1'b0;
    endtask

    task automatic test_input_pause();
        set_transform(oct_pkg::MODE_RGB, oct_pkg::DIR_INV);
        repeat (20) send_pixel(rand_pixel());
        wait_all_results();
        repeat (20) send_pixel(rand_pixel());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_all_settings();
        test_random_pixels();
        test_output_stall();
        test_input_pause();
        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
